@@ sv/slpd_pkg.sv @@
// Shared types, constants and helpers for the stop line pattern detector.
`timescale 1ns / 1ps

package slpd_pkg;

  // Defaults for the top level parameters.
  localparam int ColumnsDefault     = 128;
  localparam int RowsScannedDefault = 20;
  localparam int EdgeMarginDefault  = 10;

  // Depth of the queue between the front and back parts.
  localparam int QueueDepth = 2;

  // Configuration register indexes.
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 9;
  localparam logic [CfgIndexW-1:0] CFG_WIDE_MIN      = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_NARROW_MIN    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_GAP_MIN       = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_HEADING_LIMIT = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_WINDOW_HALF   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_MIN_FAR_ROW   = 3'd5;

  // Pattern state code of the last bar, as it shows on the result port.
  localparam logic [2:0] PAT_LAST_BAR = 3'd5;

  // Register values after reset.
  localparam logic [6:0] WideMinReset      = 7'd10;
  localparam logic [6:0] NarrowMinReset    = 7'd2;
  localparam logic [6:0] GapMinReset       = 7'd2;
  localparam logic [8:0] HeadingLimitReset = 9'd50;
  localparam logic [7:0] WindowHalfReset   = 8'd50;
  localparam logic [5:0] MinFarRowReset    = 6'd11;

  // What the front part found at one column.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_NEWROW = 2'd1,
    EV_RISE   = 2'd2,
    EV_FALL   = 2'd3
  } slpd_event_e;

  // One classified column as it travels through the queue.
  typedef struct packed {
    slpd_event_e kind;
    logic [6:0]  pos;
    logic        heading_ok;
  } slpd_token_t;

  // Bar and gap minimums used by the back part.
  typedef struct packed {
    logic [6:0] wide_min;
    logic [6:0] narrow_min;
    logic [6:0] gap_min;
  } slpd_bar_cfg_t;

  // Window narrowing, 7*row/10, as a multiply by 1435/2048. The error stays
  // well below the smallest fractional step for every 6-bit row.
  function automatic logic [5:0] slpd_slope(input logic [5:0] row);
    logic [16:0] prod;
    prod = 17'(row) * 17'd1435;
    return prod[16:11];
  endfunction

endpackage

@@ sv/slpd_front.sv @@
// Front part: merges the pixels, finds edges inside the scan window and classifies each column.
`timescale 1ns / 1ps

module slpd_front
  import slpd_pkg::*;
#(
  parameter int COLUMNS      = ColumnsDefault,
  parameter int ROWS_SCANNED = RowsScannedDefault,
  parameter int EDGE_MARGIN  = EdgeMarginDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              pix_top_i,
  input  logic              pix_mid_i,
  input  logic              pix_bot_i,
  input  logic [6:0]        column_i,
  input  logic [5:0]        row_i,
  input  logic [7:0]        center_i,
  input  logic signed [9:0] heading_i,
  input  logic [5:0]        far_row_i,
  input  logic [8:0]        heading_limit_i,
  input  logic [7:0]        window_half_i,
  input  logic [5:0]        min_far_row_i,
  output slpd_token_t       token_o
);

  localparam int LimitCol = COLUMNS - EDGE_MARGIN;
  localparam logic signed [10:0] LimitColS = 11'(LimitCol);
  localparam logic [6:0] RowsScannedW = 7'(ROWS_SCANNED);

  logic              prev_pixel_q, prev_pixel_d;
  logic              pix;
  logic              gate;
  logic              in_window;
  logic [6:0]        pos;
  logic [5:0]        slope;
  logic signed [10:0] pos_s, left, right, left_c, right_c;
  logic signed [10:0] heading_ext, heading_mag;

  // Merged pixel, forced to white inside the right margin.
  always_comb begin
    pix = pix_top_i | pix_mid_i | pix_bot_i;
    if ($signed({4'b0, column_i}) >= LimitColS) begin
      pix = 1'b0;
    end
  end

  // Scan window around the track centre, narrowing with the row.
  always_comb begin
    pos     = column_i - 7'd1;
    pos_s   = $signed({4'b0, pos});
    slope   = slpd_slope(row_i);
    left    = $signed({3'b0, center_i}) + $signed({5'b0, slope})
              - $signed({3'b0, window_half_i});
    right   = $signed({3'b0, center_i}) - $signed({5'b0, slope})
              + $signed({3'b0, window_half_i});
    left_c  = (left < 11'sd0) ? 11'sd0 : left;
    right_c = (right > LimitColS) ? LimitColS : right;
    in_window = (pos_s >= left_c) && (pos_s < right_c);
    gate    = (far_row_i > min_far_row_i) && ({1'b0, row_i} < RowsScannedW);
  end

  // Heading check, settled here so the back part only needs one flag.
  always_comb begin
    heading_ext = {heading_i[9], heading_i};
    heading_mag = (heading_ext < 11'sd0) ? -heading_ext : heading_ext;
  end

  // Classification of the column into one event.
  always_comb begin
    token_o.pos        = pos;
    token_o.heading_ok = heading_mag[9:0] < {1'b0, heading_limit_i};
    token_o.kind       = EV_NONE;
    if (column_i == 7'd0) begin
      token_o.kind = EV_NEWROW;
    end else if (gate && in_window) begin
      if (!prev_pixel_q && pix) begin
        token_o.kind = EV_RISE;
      end else if (prev_pixel_q && !pix) begin
        token_o.kind = EV_FALL;
      end
    end
  end

  // The previous pixel follows every accepted transaction.
  assign prev_pixel_d = accept_i ? pix : prev_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pixel_q <= 1'b0;
    end else begin
      prev_pixel_q <= prev_pixel_d;
    end
  end

endmodule

@@ sv/slpd_queue.sv @@
// Short queue of classified columns between the front and back parts.
`timescale 1ns / 1ps

module slpd_queue
  import slpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  slpd_token_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output slpd_token_t pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW:0] DepthW = (PtrW+1)'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  slpd_token_t       mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == DepthW);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill count guards it.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/slpd_back.sv @@
// Back part: runs the bar pattern state machine and holds the result register.
`timescale 1ns / 1ps

module slpd_back
  import slpd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slpd_bar_cfg_t cfg_i,
  input  logic          tok_valid_i,
  input  slpd_token_t   tok_i,
  output logic          tok_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          stop_hit_o,
  output logic          stopped_o,
  output logic [2:0]    pattern_state_o
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_BAR1   = 3'd1,
    MODE_GAP1   = 3'd2,
    MODE_NARROW = 3'd3,
    MODE_GAP2   = 3'd4,
    MODE_BAR3   = 3'd5
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [6:0]  rise_q, rise_d, fall_q, fall_d;
  logic        stopped_q, stopped_d;
  logic        out_valid_q, out_valid_d;
  logic        hit_q, hit_d;
  logic        take;
  logic [7:0]  gap, width;
  logic        gap_ok, wide_ok, narrow_ok;

  // A token is taken whenever the result register is free or being drained.
  assign take      = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign tok_pop_o = take;

  // Signed distances between edge positions; negative ones fail every test.
  always_comb begin
    gap       = {1'b0, tok_i.pos} - {1'b0, fall_q};
    width     = {1'b0, tok_i.pos} - {1'b0, rise_q};
    gap_ok    = !gap[7] && (gap[6:0] >= cfg_i.gap_min);
    wide_ok   = !width[7] && (width[6:0] >= cfg_i.wide_min);
    narrow_ok = !width[7] && (width[6:0] >= cfg_i.narrow_min) &&
                (width[6:0] < cfg_i.wide_min);
  end

  // Pattern transitions for one taken token.
  always_comb begin
    mode_d    = mode_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    stopped_d = stopped_q;
    hit_d     = 1'b0;
    case (tok_i.kind)
      EV_NEWROW: begin
        mode_d = MODE_IDLE;
      end
      EV_RISE: begin
        rise_d = tok_i.pos;
        case (mode_q)
          MODE_IDLE: mode_d = MODE_BAR1;
          MODE_GAP1: mode_d = gap_ok ? MODE_NARROW : MODE_IDLE;
          MODE_GAP2: mode_d = gap_ok ? MODE_BAR3 : MODE_IDLE;
          default:   mode_d = MODE_IDLE;
        endcase
      end
      EV_FALL: begin
        fall_d = tok_i.pos;
        case (mode_q)
          MODE_BAR1: begin
            if (wide_ok) begin
              mode_d = MODE_GAP1;
            end
          end
          MODE_NARROW: begin
            if (narrow_ok) begin
              mode_d = MODE_GAP2;
            end
          end
          MODE_BAR3: begin
            if (wide_ok && tok_i.heading_ok) begin
              hit_d     = 1'b1;
              stopped_d = 1'b1;
            end
          end
          default: mode_d = MODE_IDLE;
        endcase
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  assign out_valid_d = take || (out_valid_q && out_stall_i);

  // Pattern state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      rise_q      <= '0;
      fall_q      <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        mode_q    <= mode_d;
        rise_q    <= rise_d;
        fall_q    <= fall_d;
        stopped_q <= stopped_d;
        hit_q     <= hit_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stop_hit_o      = hit_q;
  assign stopped_o       = stopped_q;
  assign pattern_state_o = mode_q;

endmodule

@@ sv/stop_line_pattern_detector.sv @@
// Top level of the stop line pattern detector: configuration, front, queue and back.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  pix_*_i, column_i, row_i, center_i,
//                                                heading_i, far_row_i
//   output   out        out_valid_o / out_stall_i stop_hit_o, stopped_o, pattern_state_o
//   config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// One column transaction is accepted per cycle while the queue is not full; its result
// passes through the queue, then is presented from the back part's result register.
// The back part's pattern state machine settles one column per cycle unless stalled.
// Reset clears the pattern state, the stopped mark and the queue, and loads the
// register defaults. A stalled output fills the two-entry queue, after which the
// input is stalled until the result register drains.
`timescale 1ns / 1ps

module stop_line_pattern_detector
  import slpd_pkg::*;
#(
  parameter int COLUMNS      = ColumnsDefault,
  parameter int ROWS_SCANNED = RowsScannedDefault,
  parameter int EDGE_MARGIN  = EdgeMarginDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 pix_top_i,
  input  logic                 pix_mid_i,
  input  logic                 pix_bot_i,
  input  logic [6:0]           column_i,
  input  logic [5:0]           row_i,
  input  logic [7:0]           center_i,
  input  logic signed [9:0]    heading_i,
  input  logic [5:0]           far_row_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 stop_hit_o,
  output logic                 stopped_o,
  output logic [2:0]           pattern_state_o
);

  logic [6:0]    wide_min_q, narrow_min_q, gap_min_q;
  logic [8:0]    heading_limit_q;
  logic [7:0]    window_half_q;
  logic [5:0]    min_far_row_q;
  logic          accept;
  logic          q_full, q_valid, q_pop;
  slpd_token_t   front_tok, back_tok;
  slpd_bar_cfg_t bar_cfg;

  // Configuration registers; each keeps only its own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_min_q      <= WideMinReset;
      narrow_min_q    <= NarrowMinReset;
      gap_min_q       <= GapMinReset;
      heading_limit_q <= HeadingLimitReset;
      window_half_q   <= WindowHalfReset;
      min_far_row_q   <= MinFarRowReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDE_MIN:      wide_min_q      <= cfg_data_i[6:0];
        CFG_NARROW_MIN:    narrow_min_q    <= cfg_data_i[6:0];
        CFG_GAP_MIN:       gap_min_q       <= cfg_data_i[6:0];
        CFG_HEADING_LIMIT: heading_limit_q <= cfg_data_i[8:0];
        CFG_WINDOW_HALF:   window_half_q   <= cfg_data_i[7:0];
        CFG_MIN_FAR_ROW:   min_far_row_q   <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  assign bar_cfg.wide_min   = wide_min_q;
  assign bar_cfg.narrow_min = narrow_min_q;
  assign bar_cfg.gap_min    = gap_min_q;

  // Front part: classification of each accepted column.
  slpd_front #(
    .COLUMNS      (COLUMNS),
    .ROWS_SCANNED (ROWS_SCANNED),
    .EDGE_MARGIN  (EDGE_MARGIN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .pix_top_i       (pix_top_i),
    .pix_mid_i       (pix_mid_i),
    .pix_bot_i       (pix_bot_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .center_i        (center_i),
    .heading_i       (heading_i),
    .far_row_i       (far_row_i),
    .heading_limit_i (heading_limit_q),
    .window_half_i   (window_half_q),
    .min_far_row_i   (min_far_row_q),
    .token_o         (front_tok)
  );

  // Queue decoupling the two parts.
  slpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_tok),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (back_tok)
  );

  // Back part: pattern state machine and results.
  slpd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (bar_cfg),
    .tok_valid_i     (q_valid),
    .tok_i           (back_tok),
    .tok_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .stop_hit_o      (stop_hit_o),
    .stopped_o       (stopped_o),
    .pattern_state_o (pattern_state_o)
  );

endmodule

@@ sv/slpd_checker.sv @@
// Port-level checks of the stop line pattern detector and their binding.
`timescale 1ns / 1ps

module slpd_checker
  import slpd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       stop_hit_o,
  input logic       stopped_o,
  input logic [2:0] pattern_state_o
);

  logic seen_stop_q;

  // Remembers that a delivered transaction already carried the stopped mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_stop_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && stopped_o) begin
      seen_stop_q <= 1'b1;
    end
  end

  // The stopped mark never drops once it has been delivered.
  a_stopped_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_stop_q) |-> stopped_o)
    else $error("stopped mark cleared after it was delivered");

  // A stop hit always comes with the stopped mark.
  a_hit_sets_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_hit_o) |-> stopped_o)
    else $error("stop hit without stopped mark");

  // A stop hit can only complete in the last bar state.
  a_hit_in_last_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_hit_o) |-> (pattern_state_o == PAT_LAST_BAR))
    else $error("stop hit outside the last bar state");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(stop_hit_o) && $stable(stopped_o) &&
       $stable(pattern_state_o)))
    else $error("stalled result changed");

endmodule

bind stop_line_pattern_detector slpd_checker u_slpd_checker (.*);
